/* hw/rtl/pngunf_pkg.sv */
package pngunf_pkg;

	// default sizes of the row store and the pixel history
	localparam int MAX_ROW_BYTES_DEF   = 8192;
	localparam int MAX_PIXEL_BYTES_DEF = 8;

	// configuration register defaults
	localparam logic [13:0] ROW_BYTES_RST  = 14'd1024;
	localparam logic [3:0]  PIXEL_BYTES_RST = 4'd4;
	localparam logic [15:0] IMAGE_ROWS_RST = 16'd1;

	// register index on the configuration port (byte address / 4)
	typedef enum logic [1:0] {
		REG_ROW_BYTES   = 2'd0,
		REG_PIXEL_BYTES = 2'd1,
		REG_IMAGE_ROWS  = 2'd2
	} reg_idx_t;

	// row filter types, anything above paeth is carried as bad
	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4,
		FILT_BAD   = 3'd5
	} filter_t;

	// predictor operands
	typedef struct packed {
		filter_t    filt;
		logic [7:0] data;
		logic [7:0] left;
		logic [7:0] up;
		logic [7:0] up_left;
	} pred_in_t;

	// predictor result
	typedef struct packed {
		logic [7:0] pix;
		logic       bad;
	} pred_out_t;

	// map a raw filter byte onto a filter type
	function automatic filter_t decode_filter(input logic [7:0] d);
		filter_t f;
		if (d > 8'(FILT_PAETH)) begin
			f = FILT_BAD;
		end else begin
			f = filter_t'(d[2:0]);
		end
		return f;
	endfunction

endpackage

/* hw/rtl/pngunf_ram.sv */
module pngunf_ram import pngunf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = MAX_ROW_BYTES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/pngunf_pred.sv */
module pngunf_pred import pngunf_pkg::*; (
	input  pred_in_t  opnd,
	output pred_out_t res
);

	logic signed [9:0] dist_a, dist_b, dist_c;
	logic [8:0]        pa, pb, pc;
	logic [8:0]        avg_sum;
	logic [7:0]        paeth_pick;

	function automatic logic [8:0] mag(input logic signed [9:0] v);
		logic signed [9:0] n;
		n = -v;
		return v[9] ? n[8:0] : v[8:0];
	endfunction

	// paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
	always_comb begin
		dist_a = $signed({2'b00, opnd.up}) - $signed({2'b00, opnd.up_left});
		dist_b = $signed({2'b00, opnd.left}) - $signed({2'b00, opnd.up_left});
		dist_c = $signed({2'b00, opnd.left}) + $signed({2'b00, opnd.up})
			- $signed({1'b0, opnd.up_left, 1'b0});
		pa = mag(dist_a);
		pb = mag(dist_b);
		pc = mag(dist_c);
		if (pa <= pb && pa <= pc) begin
			paeth_pick = opnd.left;
		end else if (pb <= pc) begin
			paeth_pick = opnd.up;
		end else begin
			paeth_pick = opnd.up_left;
		end
	end

	// filter select, sums wrap at 8 bits
	always_comb begin
		avg_sum = {1'b0, opnd.left} + {1'b0, opnd.up};
		res.bad = 1'b0;
		unique case (opnd.filt)
			FILT_NONE:  res.pix = opnd.data;
			FILT_SUB:   res.pix = opnd.data + opnd.left;
			FILT_UP:    res.pix = opnd.data + opnd.up;
			FILT_AVG:   res.pix = opnd.data + avg_sum[8:1];
			FILT_PAETH: res.pix = opnd.data + paeth_pick;
			default: begin
				res.pix = opnd.data;
				res.bad = 1'b1;
			end
		endcase
	end

endmodule

/* hw/rtl/png_scanline_unfilter_unit.sv */
// channel   | handshake                  | payload
// in        | in_valid / in_ready        | data_byte, frame_start
// out       | out_valid / out_ready      | pixel_byte, row_end, frame_end, bad_filter
// config    | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// one byte per cycle sustained while out_ready is high; a pixel byte passes through the
// predictor stage and the output register to out, a filter byte is taken and yields nothing
// the rate is set by the row store: read in the cycle a byte is taken, written back as it
// leaves the predictor stage, the left and above-left history updated in that same cycle
// reset sets the registers to their defaults and the position to the first row of a frame;
// the row store is not cleared, the first row of a frame reads zeros above
// with out_ready low the output register and the predictor stage each hold one byte,
// then in_ready drops
module png_scanline_unfilter_unit import pngunf_pkg::*; #(
	parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
	parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	// output stream
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pixel_byte,
	output logic        row_end,
	output logic        frame_end,
	output logic        bad_filter,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(MAX_ROW_BYTES);
	localparam int CW = AW + 1;
	localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// configuration registers
	logic [13:0] row_bytes_q;
	logic [3:0]  pixel_bytes_q;
	logic [15:0] image_rows_q;
	logic        cfg_wr;

	// front position state
	logic [AW-1:0] col_q;
	logic [15:0]   row_q;
	filter_t       filt_q;
	logic          await_q;
	logic          first_q;

	// effective settings
	logic [CW-1:0] rb_eff;
	logic [3:0]    bpp_eff;
	logic [15:0]   rows_eff;
	logic [HW-1:0] hist_idx;

	// accept decode
	logic          in_acc;
	logic          await_eff;
	logic          pix_acc;
	logic [CW-1:0] col_next;
	logic          last_c;
	logic          fend_c;
	logic          left_ok_c;

	// predictor stage
	logic          s1_valid_q;
	logic          s1_adv;
	logic [7:0]    data_s1;
	filter_t       filt_s1;
	logic [AW-1:0] col_s1;
	logic          first_s1;
	logic          left_ok_s1;
	logic          last_s1;
	logic          fend_s1;

	logic [7:0]    above_rd;
	pred_in_t      pred_in;
	pred_out_t     pred_out;

	logic [7:0]    left_hist_q [MAX_PIXEL_BYTES];
	logic [7:0]    up_hist_q   [MAX_PIXEL_BYTES];

	// output register
	logic          out_valid_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q   <= ROW_BYTES_RST;
			pixel_bytes_q <= PIXEL_BYTES_RST;
			image_rows_q  <= IMAGE_ROWS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROW_BYTES:   row_bytes_q   <= pwdata[13:0];
				REG_PIXEL_BYTES: pixel_bytes_q <= pwdata[3:0];
				REG_IMAGE_ROWS:  image_rows_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// configuration reads
	always_comb begin
		unique case (paddr[3:2])
			REG_ROW_BYTES:   prdata = {18'd0, row_bytes_q};
			REG_PIXEL_BYTES: prdata = {28'd0, pixel_bytes_q};
			REG_IMAGE_ROWS:  prdata = {16'd0, image_rows_q};
			default:         prdata = 32'd0;
		endcase
	end

	// clamp settings into range
	always_comb begin
		if (row_bytes_q == 14'd0) begin
			rb_eff = CW'(1);
		end else if (32'(row_bytes_q) > 32'(MAX_ROW_BYTES)) begin
			rb_eff = CW'(MAX_ROW_BYTES);
		end else begin
			rb_eff = CW'(row_bytes_q);
		end
		if (pixel_bytes_q == 4'd0) begin
			bpp_eff = 4'd1;
		end else if (32'(pixel_bytes_q) > 32'(MAX_PIXEL_BYTES)) begin
			bpp_eff = 4'(MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = pixel_bytes_q;
		end
		rows_eff = (image_rows_q == 16'd0) ? 16'd1 : image_rows_q;
		hist_idx = HW'(bpp_eff - 4'd1);
	end

	// handshake and position decode
	assign s1_adv    = s1_valid_q & (~out_valid_q | out_ready);
	assign in_ready  = ~s1_valid_q | s1_adv;
	assign in_acc    = in_valid & in_ready;
	assign await_eff = frame_start | await_q;
	assign pix_acc   = in_acc & ~await_eff;
	assign col_next  = {1'b0, col_q} + CW'(1);
	assign last_c    = col_next >= rb_eff;
	assign fend_c    = last_c & (({1'b0, row_q} + 17'd1) >= {1'b0, rows_eff});
	assign left_ok_c = 32'(col_q) >= 32'(bpp_eff);

	// row and column tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			filt_q  <= FILT_NONE;
			await_q <= 1'b1;
			first_q <= 1'b1;
		end else if (in_acc) begin
			if (await_eff) begin
				filt_q  <= decode_filter(data_byte);
				await_q <= 1'b0;
				col_q   <= '0;
				if (frame_start) begin
					row_q   <= '0;
					first_q <= 1'b1;
				end
			end else if (last_c) begin
				col_q   <= '0;
				await_q <= 1'b1;
				if (fend_c) begin
					row_q   <= '0;
					first_q <= 1'b1;
				end else begin
					row_q   <= row_q + 16'd1;
					first_q <= 1'b0;
				end
			end else begin
				col_q <= col_next[AW-1:0];
			end
		end
	end

	// predictor stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// predictor stage payload
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			data_s1    <= data_byte;
			filt_s1    <= filt_q;
			col_s1     <= col_q;
			first_s1   <= first_q;
			left_ok_s1 <= left_ok_c;
			last_s1    <= last_c;
			fend_s1    <= fend_c;
		end
	end

	// previous row store: read on accept, written as the byte leaves the stage
	pngunf_ram #(
		.WIDTH(8),
		.DEPTH(MAX_ROW_BYTES)
	) u_row_store (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(col_s1),
		.wdata(pred_out.pix),
		.re   (pix_acc),
		.raddr(col_q),
		.rdata(above_rd)
	);

	// neighbors, zero outside the image
	always_comb begin
		pred_in.filt    = filt_s1;
		pred_in.data    = data_s1;
		pred_in.left    = left_ok_s1 ? left_hist_q[hist_idx] : 8'd0;
		pred_in.up      = first_s1 ? 8'd0 : above_rd;
		pred_in.up_left = (left_ok_s1 && !first_s1) ? up_hist_q[hist_idx] : 8'd0;
	end

	pngunf_pred u_pred (
		.opnd(pred_in),
		.res (pred_out)
	);

	// one-pixel history of this row and the row above
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			left_hist_q[0] <= pred_out.pix;
			up_hist_q[0]   <= pred_in.up;
			for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
				left_hist_q[i] <= left_hist_q[i-1];
				up_hist_q[i]   <= up_hist_q[i-1];
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_byte <= pred_out.pix;
			row_end    <= last_s1;
			frame_end  <= fend_s1;
			bad_filter <= pred_out.bad;
		end
	end

	assign out_valid = out_valid_q;

	// the store is never read and written at one entry in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && s1_adv) |-> (col_q != col_s1))
		else $error("row store read and write collide");

	// a frame end transaction always closes a row
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_end || row_end))
		else $error("frame end without row end");

	// input stalls only with both stages full and the output blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid_q && out_valid_q && !out_ready))
		else $error("input stalled with room in the pipeline");

	// a byte taken at the last column sends the front back to a filter byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && last_c) |=> (await_q && col_q == '0))
		else $error("row end did not rearm filter byte");

endmodule
